FILE: hdl/source_text_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the source text tokenizer checkers
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication
`define STT_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define STT_CHECK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, constants and helpers of the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    // Internal width of line, column and length counters
    localparam int CNT_W = 16;
    localparam int OFS_W = 32;
    localparam int FLD_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [OFS_W-1:0] OFS_MAX = '1;

    // Token kinds as they appear on the output tuser
    typedef enum logic [2:0] {
        KIND_LET     = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_PLUS    = 3'd3,
        KIND_EQUAL   = 3'd4,
        KIND_SEMI    = 3'd5,
        KIND_END     = 3'd6,
        KIND_UNKNOWN = 3'd7
    } tok_kind_t;

    // Input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Keyword match progress: bytes of "let" matched, or failed
    localparam logic [2:0] KW_START = 3'd0;
    localparam logic [2:0] KW_DONE  = 3'd3;
    localparam logic [2:0] KW_FAIL  = 3'd4;

    // Character codes
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_T      = 8'h74;

    // One token record
    typedef struct packed {
        tok_kind_t         kind;
        logic [FLD_W-1:0]  line;
        logic [FLD_W-1:0]  column;
        logic [OFS_W-1:0]  offset;
        logic [FLD_W-1:0]  length;
        logic [7:0]        uchar;
        logic              last;
    } tok_rec_t;

    // Records produced by one accepted word, in output order
    typedef struct packed {
        logic [1:0] count;
        tok_rec_t   rec0;
        tok_rec_t   rec1;
    } tok_res_t;

    // Byte of the keyword at a given match position
    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_L;
            2'd1:    ch = CH_E;
            2'd2:    ch = CH_T;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

    // Show a counter in a 16-bit field, clamped to the field's top value
    function automatic logic [FLD_W-1:0] clamp16(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[FLD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-serial lexer: source bytes in, token records out.
// ----------------------------------------------------------------------------
// Input words carry one source byte (tuser = 0) or an end-of-input mark
// (tuser = 1). Each output word is one token record: kind on tuser, position,
// length and the single-byte token code on tdata, tlast on the final record
// caused by one input word.
// An accepted word is decoded in the same cycle and its records (zero, one
// or two) are registered in a four-entry output queue, whose oldest record
// shows on m_axis. An identifier or number comes out with the word that
// ends it.
// Throughput is one input word per cycle while at most two records wait;
// the output side drains one record per cycle while m_axis_tready is high,
// so input that yields two records per word runs at the output's pace.
// Reset clears the scanner to line 1, column 1, offset 0 and empties the
// queue. When the receiver stalls, the queue fills and s_axis_tready drops
// once fewer than two free entries remain; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer
    import stt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic [0:0]  s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] token_line, [31:16] token_column, [63:32] token_offset,
    // [79:64] token_length, [87:80] unknown_char
    output logic [87:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser,   // [2:0] token_kind
    output logic             m_axis_tlast
);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    tok_res_t          res;
    logic              in_fire, pop;
    tok_rec_t          q_mem [Q_DEPTH];
    tok_rec_t          head;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;

    assign s_axis_tready = (cnt_reg <= (Q_AW+1)'(Q_DEPTH - 2));
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    stt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .op        (s_axis_tuser[0]),
        .char_code (s_axis_tdata),
        .res       (res)
    );

    // Present the queue head
    assign head          = q_mem[rd_ptr_reg];
    assign m_axis_tvalid = (cnt_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {head.uchar, head.length, head.offset, head.column, head.line};

    // Advance pointers and fill count
    assign wr_ptr_next = wr_ptr_reg + Q_AW'(res.count);
    assign rd_ptr_next = rd_ptr_reg + Q_AW'(pop);
    assign cnt_next    = cnt_reg + (Q_AW+1)'(res.count) - (Q_AW+1)'(pop);

    // Write records into the queue
    always_ff @(posedge clk)
    begin
        if (res.count != 2'd0)
            q_mem[wr_ptr_reg] <= res.rec0;
        if (res.count == 2'd2)
            q_mem[wr_ptr_reg + Q_AW'(1)] <= res.rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/stt_core.sv
// ----------------------------------------------------------------------------
// stt_core
// Scanner state and per-byte token decode: one accepted word per cycle,
// up to two token records out, all in one pass of logic.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_core
    import stt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_fire,
    input  wire logic     op,
    input  wire logic [7:0] char_code,
    output tok_res_t      res
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0] line_reg, line_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic [CNT_W-1:0] scol_reg, scol_next;
    logic [OFS_W-1:0] sofs_reg, sofs_next;
    logic [CNT_W-1:0] plen_reg, plen_next;
    logic [2:0]       kw_reg, kw_next;

    logic             c_letter, c_digit, c_space, c_word;
    logic             pending;
    logic [OFS_W-1:0] ofs_adv;
    logic [CNT_W-1:0] line_adv, col_adv;
    logic [2:0]       kw_adv;
    tok_rec_t         flush_rec, cur_rec;
    tok_kind_t        single_kind;

    // Classify the byte
    assign c_letter = is_letter(char_code);
    assign c_digit  = is_digit(char_code);
    assign c_space  = is_space(char_code);
    assign c_word   = c_letter || c_digit || (char_code == CH_USCORE);
    assign pending  = (mode_reg != MODE_IDLE);

    // Position after this byte
    assign ofs_adv  = (ofs_reg == OFS_MAX) ? ofs_reg : ofs_reg + OFS_W'(1);
    assign line_adv = (char_code == CH_NL) ? sat_inc(line_reg) : line_reg;
    assign col_adv  = (char_code == CH_NL) ? CNT_W'(1) : sat_inc(col_reg);

    // Keyword match step
    assign kw_adv = ((kw_reg < KW_DONE) && (char_code == kw_char(kw_reg[1:0])))
                  ? kw_reg + 3'd1 : KW_FAIL;

    // Single-byte token kind
    always_comb
    begin
        priority if (char_code == CH_PLUS)  single_kind = KIND_PLUS;
        else if (char_code == CH_EQUAL)     single_kind = KIND_EQUAL;
        else if (char_code == CH_SEMI)      single_kind = KIND_SEMI;
        else                                single_kind = KIND_UNKNOWN;
    end

    // Record of the pending identifier or number
    always_comb
    begin
        flush_rec        = '0;
        if (mode_reg == MODE_IDENT)
            flush_rec.kind = (kw_reg == KW_DONE) ? KIND_LET : KIND_IDENT;
        else
            flush_rec.kind = KIND_NUMBER;
        flush_rec.line   = clamp16(line_reg);
        flush_rec.column = clamp16(scol_reg);
        flush_rec.offset = sofs_reg;
        flush_rec.length = clamp16(plen_reg);
    end

    // Record at the current position: end of input or a single-byte token
    always_comb
    begin
        cur_rec        = '0;
        cur_rec.line   = clamp16(line_reg);
        cur_rec.column = clamp16(col_reg);
        cur_rec.offset = ofs_reg;
        if (op == OP_END)
        begin
            cur_rec.kind = KIND_END;
        end
        else
        begin
            cur_rec.kind   = single_kind;
            cur_rec.length = FLD_W'(1);
            cur_rec.uchar  = char_code;
        end
    end

    // Next state and records for the accepted word
    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        ofs_next  = ofs_reg;
        scol_next = scol_reg;
        sofs_next = sofs_reg;
        plen_next = plen_reg;
        kw_next   = kw_reg;
        res       = '0;

        if (in_fire)
        begin
            if (op == OP_END)
            begin
                // Flush, close the stream and start over
                if (pending)
                begin
                    res.count = 2'd2;
                    res.rec0  = flush_rec;
                    res.rec1  = cur_rec;
                end
                else
                begin
                    res.count = 2'd1;
                    res.rec0  = cur_rec;
                end
                mode_next = MODE_IDLE;
                line_next = CNT_W'(1);
                col_next  = CNT_W'(1);
                ofs_next  = '0;
                scol_next = '0;
                sofs_next = '0;
                plen_next = '0;
                kw_next   = KW_START;
            end
            else if (((mode_reg == MODE_IDENT) && c_word) ||
                     ((mode_reg == MODE_NUMBER) && c_digit))
            begin
                // Extend the pending token
                plen_next = sat_inc(plen_reg);
                if (mode_reg == MODE_IDENT)
                    kw_next = kw_adv;
                ofs_next  = ofs_adv;
                line_next = line_adv;
                col_next  = col_adv;
            end
            else
            begin
                // Close any pending token
                if (pending)
                begin
                    res.count = 2'd1;
                    res.rec0  = flush_rec;
                    mode_next = MODE_IDLE;
                end
                if (c_space)
                begin
                    // skip
                end
                else if (c_letter || c_digit)
                begin
                    mode_next = c_letter ? MODE_IDENT : MODE_NUMBER;
                    scol_next = col_reg;
                    sofs_next = ofs_reg;
                    plen_next = CNT_W'(1);
                    if (c_letter)
                        kw_next = (char_code == CH_L) ? 3'd1 : KW_FAIL;
                    else
                        kw_next = KW_START;
                end
                else
                begin
                    if (pending)
                        res.rec1 = cur_rec;
                    else
                        res.rec0 = cur_rec;
                    res.count = res.count + 2'd1;
                end
                ofs_next  = ofs_adv;
                line_next = line_adv;
                col_next  = col_adv;
            end

            // Mark the last record of this word
            if (res.count == 2'd1)
                res.rec0.last = 1'b1;
            else if (res.count == 2'd2)
                res.rec1.last = 1'b1;
        end
    end

    // Hold scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            line_reg <= CNT_W'(1);
            col_reg  <= CNT_W'(1);
            ofs_reg  <= '0;
            scol_reg <= '0;
            sofs_reg <= '0;
            plen_reg <= '0;
            kw_reg   <= KW_START;
        end
        else
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            ofs_reg  <= ofs_next;
            scol_reg <= scol_next;
            sofs_reg <= sofs_next;
            plen_reg <= plen_next;
            kw_reg   <= kw_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the token stream of the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_text_tokenizer_assert.svh"

module stt_checker
    import stt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [0:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [87:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // Hold a stalled word
    `STT_CHECK_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

    // End of input always leaves a record waiting on the output
    `STT_CHECK_NXT(a_end_out, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], m_axis_tvalid, "no record after end of input")

    // End record closes the group and has no length or byte
    `STT_CHECK_IMP(a_end_rec, m_axis_tvalid && (m_axis_tuser == KIND_END), m_axis_tlast && (m_axis_tdata[79:64] == 16'h0000) && (m_axis_tdata[87:80] == 8'h00), "malformed end record")

    // Other tokens have a length and a valid position
    `STT_CHECK_IMP(a_tok_pos, m_axis_tvalid && (m_axis_tuser != KIND_END), (m_axis_tdata[79:64] != 16'h0000) && (m_axis_tdata[15:0] != 16'h0000) && (m_axis_tdata[31:16] != 16'h0000), "token with zero length, line or column")

    // Plus token carries its byte and is one byte long
    `STT_CHECK_IMP(a_plus_rec, m_axis_tvalid && (m_axis_tuser == KIND_PLUS), (m_axis_tdata[87:80] == CH_PLUS) && (m_axis_tdata[79:64] == 16'h0001), "malformed plus record")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire

FILE: sim/source_text_tokenizer_check.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_check
// Watches both streams of the tokenizer, predicts every token record from the
// accepted input words and compares the records as they leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module source_text_tokenizer_check
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [0:0]  s_axis_tuser,   // [0] op
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] line, [31:16] column, [63:32] offset, [79:64] length, [87:80] char
    input  logic [87:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    input  logic        m_axis_tlast,
    output int          fault_count,
    output int          tokens_due,
    output int          records_checked,
    output logic [7:0]  kinds_seen
);

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_IDENT  = 2'd1,
        SCAN_NUMBER = 2'd2
    } scan_state_t;

    // Scanner copy kept by the checker
    scan_state_t      scan_state;
    logic [CNT_W-1:0] cur_line;
    logic [CNT_W-1:0] cur_col;
    logic [OFS_W-1:0] cur_ofs;
    logic [CNT_W-1:0] tok_col;
    logic [OFS_W-1:0] tok_ofs;
    logic [CNT_W-1:0] tok_len;
    logic [2:0]       kw_seen;

    tok_rec_t due_tokens[$];
    int       faults_shown;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    // Show a counter in a 16-bit record field
    function automatic logic [FLD_W-1:0] to_field(input logic [CNT_W-1:0] v);
        return (64'(v) > 64'hFFFF) ? 16'hFFFF : FLD_W'(v);
    endfunction

    task automatic restart_stream();
        scan_state = SCAN_IDLE;
        cur_line   = CNT_W'(1);
        cur_col    = CNT_W'(1);
        cur_ofs    = '0;
        tok_col    = '0;
        tok_ofs    = '0;
        tok_len    = '0;
        kw_seen    = KW_START;
    endtask

    task automatic push_token(input tok_kind_t kind, input logic [CNT_W-1:0] col,
                              input logic [OFS_W-1:0] ofs, input logic [CNT_W-1:0] len,
                              input logic [7:0] ch);
        tok_rec_t r;
        r.kind   = kind;
        r.line   = to_field(cur_line);
        r.column = to_field(col);
        r.offset = ofs;
        r.length = to_field(len);
        r.uchar  = ch;
        r.last   = 1'b0;
        due_tokens.push_back(r);
    endtask

    // Emit the identifier, keyword or number that is waiting, if any
    task automatic flush_pending();
        if (scan_state == SCAN_IDENT)
            push_token((kw_seen == KW_DONE) ? KIND_LET : KIND_IDENT, tok_col, tok_ofs,
                       tok_len, 8'h00);
        else if (scan_state == SCAN_NUMBER)
            push_token(KIND_NUMBER, tok_col, tok_ofs, tok_len, 8'h00);
        scan_state = SCAN_IDLE;
    endtask

    task automatic step_position(input logic [7:0] c);
        if (cur_ofs != OFS_MAX)
            cur_ofs = cur_ofs + OFS_W'(1);
        if (c == CH_NL) begin
            cur_line = bump(cur_line);
            cur_col  = CNT_W'(1);
        end
        else
            cur_col = bump(cur_col);
    endtask

    task automatic start_token(input scan_state_t mode);
        scan_state = mode;
        tok_col    = cur_col;
        tok_ofs    = cur_ofs;
        tok_len    = CNT_W'(1);
    endtask

    // Work out the records caused by one accepted input word
    task automatic lex_word(input logic op, input logic [7:0] c);
        int        size_at_start;
        logic      letter;
        logic      digit;
        logic      blank;
        logic [7:0] kw_next;
        tok_kind_t k;
        tok_rec_t  tail;
        size_at_start = due_tokens.size();
        letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        digit  = (c >= "0") && (c <= "9");
        blank  = (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
        case (kw_seen)
            3'd0:    kw_next = CH_L;
            3'd1:    kw_next = CH_E;
            3'd2:    kw_next = CH_T;
            default: kw_next = 8'h00;
        endcase
        if (op == OP_END) begin
            flush_pending();
            push_token(KIND_END, cur_col, cur_ofs, '0, 8'h00);
            restart_stream();
        end
        else if (scan_state == SCAN_IDENT && (letter || digit || c == CH_USCORE)) begin
            tok_len = bump(tok_len);
            kw_seen = (kw_seen < KW_DONE && c == kw_next) ? kw_seen + 3'd1 : KW_FAIL;
            step_position(c);
        end
        else if (scan_state == SCAN_NUMBER && digit) begin
            tok_len = bump(tok_len);
            step_position(c);
        end
        else begin
            flush_pending();
            if (blank) begin
                // whitespace only moves the position
            end
            else if (letter) begin
                start_token(SCAN_IDENT);
                kw_seen = (c == CH_L) ? 3'd1 : KW_FAIL;
            end
            else if (digit) begin
                start_token(SCAN_NUMBER);
                kw_seen = KW_START;
            end
            else begin
                if (c == CH_PLUS)
                    k = KIND_PLUS;
                else if (c == CH_EQUAL)
                    k = KIND_EQUAL;
                else if (c == CH_SEMI)
                    k = KIND_SEMI;
                else
                    k = KIND_UNKNOWN;
                push_token(k, cur_col, cur_ofs, CNT_W'(1), c);
            end
            step_position(c);
        end
        // Mark the final record of this word
        if (due_tokens.size() > size_at_start) begin
            tail      = due_tokens.pop_back();
            tail.last = 1'b1;
            due_tokens.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        tok_rec_t got;
        tok_rec_t want;
        if (!rst_n) begin
            restart_stream();
            due_tokens.delete();
            fault_count     <= 0;
            tokens_due      <= 0;
            records_checked <= 0;
            kinds_seen      <= '0;
            faults_shown     = 0;
        end
        else begin
            // Predict from each accepted input word
            if (s_axis_tvalid && s_axis_tready)
                lex_word(s_axis_tuser[0], s_axis_tdata);

            // Compare each accepted record with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind   = tok_kind_t'(m_axis_tuser);
                got.line   = m_axis_tdata[15:0];
                got.column = m_axis_tdata[31:16];
                got.offset = m_axis_tdata[63:32];
                got.length = m_axis_tdata[79:64];
                got.uchar  = m_axis_tdata[87:80];
                got.last   = m_axis_tlast;
                records_checked <= records_checked + 1;
                kinds_seen[got.kind] <= 1'b1;
                if (due_tokens.size() == 0) begin
                    fault_count <= fault_count + 1;
                    if (faults_shown < 10)
                        $display("%0t: record with nothing predicted: kind %0d line %0d",
                                 $realtime, got.kind, got.line);
                    faults_shown++;
                end
                else begin
                    want = due_tokens.pop_front();
                    if (got.kind !== want.kind || got.line !== want.line ||
                        got.column !== want.column || got.offset !== want.offset ||
                        got.length !== want.length || got.uchar !== want.uchar ||
                        got.last !== want.last) begin
                        fault_count <= fault_count + 1;
                        if (faults_shown < 10) begin
                            $display("%0t: token mismatch (kind line col ofs len char last)",
                                     $realtime);
                            $display("  expected %0d %0d %0d %0d %0d %02h %0b", want.kind,
                                     want.line, want.column, want.offset, want.length,
                                     want.uchar, want.last);
                            $display("  actual   %0d %0d %0d %0d %0d %02h %0b", got.kind,
                                     got.line, got.column, got.offset, got.length,
                                     got.uchar, got.last);
                        end
                        faults_shown++;
                    end
                end
            end
            tokens_due <= due_tokens.size();
        end
    end

endmodule

FILE: sim/source_text_tokenizer_test.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_test
// Feeds the tokenizer directed text, long runs at full rate, and random
// statements mixed with noise and end marks, under bursty input and a
// stalling receiver. The checker beside the block predicts and compares
// every token record.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module source_text_tokenizer_test;
    import stt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic [0:0]  s_axis_tuser;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [15:0] line, [31:16] column, [63:32] offset, [79:64] length, [87:80] char
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;   // [2:0] token_kind
    logic        m_axis_tlast;

    int          fault_count;
    int          tokens_due;
    int          records_checked;
    logic [7:0]  kinds_seen;

    int          words_sent;
    int          burst_left;
    logic        full_rate;

    source_text_tokenizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    source_text_tokenizer_check i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .fault_count     (fault_count),
        .tokens_due      (tokens_due),
        .records_checked (records_checked),
        .kinds_seen      (kinds_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: stall rate is picked at random, from none to heavy
    int stall_left = 0;
    int stall_pct  = 0;
    int rx_cycle   = 0;
    always @(posedge clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 50;
            endcase
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 8);
        end
    end

    // Hand one word over; a new burst may open with an idle gap
    task automatic send_word(input logic op, input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = full_rate ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= op;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(OP_BYTE, s[i]);
    endtask

    task automatic send_blank(input int min_count);
        int n;
        int pick;
        n = $urandom_range(min_count, 2);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            send_word(OP_BYTE, (pick < 5) ? CH_SPACE : 8'($urandom_range(9, 13)));
        end
    endtask

    task automatic send_name();
        int        n;
        int        pick;
        logic [7:0] ch;
        case ($urandom_range(0, 7))
            0: send_text("let");
            1: send_text("le");
            2: send_text("lets");
            3: send_text("LET");
            default:
            begin
                ch = $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                          : 8'("A" + $urandom_range(0, 25));
                send_word(OP_BYTE, ch);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        ch = 8'("a" + $urandom_range(0, 25));
                    else if (pick < 8)
                        ch = 8'("0" + $urandom_range(0, 9));
                    else
                        ch = CH_USCORE;
                    send_word(OP_BYTE, ch);
                end
            end
        endcase
    endtask

    task automatic send_number();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_word(OP_BYTE, 8'("0" + $urandom_range(0, 9)));
    endtask

    // One assignment: [let] name = term {+ term} ;
    task automatic send_statement();
        int terms;
        if ($urandom_range(0, 2) != 0) begin
            send_text("let");
            send_blank(1);
        end
        send_name();
        send_blank(0);
        send_word(OP_BYTE, CH_EQUAL);
        send_blank(0);
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) begin
                send_blank(0);
                send_word(OP_BYTE, CH_PLUS);
                send_blank(0);
            end
            if ($urandom_range(0, 1))
                send_number();
            else
                send_name();
        end
        send_word(OP_BYTE, CH_SEMI);
        send_blank(0);
    endtask

    initial begin
        int pick;
        int n;
        logic drained;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_BYTE;
        words_sent     = 0;
        burst_left     = 0;
        full_rate      = 1'b0;
        drained        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keyword, identifier with underscore and digit, number
        // ending in a letter, leading underscore, extreme bytes, end marks
        send_text("let a_1=9x+_;");
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, CH_NL);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h09);
        send_text("le");
        send_word(OP_END, 8'hFF);
        send_text("7");
        send_word(OP_END, 8'h00);

        // Long identifier, single-byte tokens and blank lines back to back
        full_rate = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(OP_BYTE, "a");
        send_text(" +=;+");
        for (int i = 0; i < 20; i++)
            send_word(OP_BYTE, CH_NL);
        send_text("x1;+;=");
        send_word(OP_END, 8'h00);
        full_rate = 1'b0;

        // Random: mostly statements, some noise, broken pieces and end marks
        while (words_sent < 1950) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_statement();
            else if (pick < 85) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_word(OP_BYTE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 94) begin
                case ($urandom_range(0, 3))
                    0: send_text("_x");
                    1: begin send_number(); send_name(); end
                    2: send_text("=;+");
                    default: send_name();
                endcase
            end
            else
                send_word(OP_END, 8'($urandom_range(0, 255)));

            // Hold off once until every predicted record has drained
            if (!drained && words_sent >= 975) begin
                drained = 1'b1;
                s_axis_tvalid <= 1'b0;
                burst_left = 0;
                @(negedge clk);
                wait (tokens_due == 0);
                @(posedge clk);
            end
        end
        send_word(OP_END, 8'h00);
        s_axis_tvalid <= 1'b0;

        @(negedge clk);
        wait (tokens_due == 0);
        repeat (20) @(posedge clk);

        $display("sent %0d words (directed text, full-rate runs, random statements)",
                 words_sent);
        $display("checked %0d token records, kinds seen mask %08b",
                 records_checked, kinds_seen);
        if (fault_count == 0 && tokens_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_core.sv
hdl/source_text_tokenizer.sv
hdl/stt_checker.sv
sim/source_text_tokenizer_check.sv
sim/source_text_tokenizer_test.sv
